// File: sv/gprs_pkg.sv
// ----------------------------------------------------------------------------
// gprs_pkg: shared types and microprogram for the rectangle sum block
// Grid sizes, control word layout, condition codes and the read-only
// microcode table that drives the datapath.
// ----------------------------------------------------------------------------
package gprs_pkg;

  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int CIDX_W    = COL_W + 1;
  localparam int RIDX_W    = ROW_W + 1;
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int AMT_W     = 16;
  localparam int SUM_W     = 32;
  localparam int UPC_W     = 4;
  localparam int TERM_W    = 2;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t S_IDLE   = 4'd0;
  localparam upc_t S_LOAD   = 4'd1;
  localparam upc_t S_A_RD   = 4'd2;
  localparam upc_t S_A_WR   = 4'd3;
  localparam upc_t S_A_NXI  = 4'd4;
  localparam upc_t S_A_DONE = 4'd5;
  localparam upc_t S_Q_TERM = 4'd6;
  localparam upc_t S_Q_RD   = 4'd7;
  localparam upc_t S_Q_ACC  = 4'd8;
  localparam upc_t S_Q_NXI  = 4'd9;
  localparam upc_t S_Q_END  = 4'd10;
  localparam upc_t S_Q_OUT  = 4'd11;

  typedef enum logic [1:0] {I_HOLD, I_LOAD, I_UP, I_DOWN} i_op_t;
  typedef enum logic [2:0] {J_HOLD, J_LOAD, J_UP, J_DOWN, J_RELOAD} j_op_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {TERM_HOLD, TERM_CLEAR, TERM_INC} term_op_t;
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_START, C_QUERY, C_J_UP_OK, C_I_UP_OK,
    C_J_DN_NZ, C_I_DN_NZ, C_TERM_EMPTY, C_TERM_MORE
  } cond_t;

  typedef struct packed {
    i_op_t    i_op;
    j_op_t    j_op;
    logic     mem_wr;
    acc_op_t  acc_op;
    term_op_t term_op;
    logic     out_stb;
    cond_t    cond;
    upc_t     target;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic query;
    logic j_up_ok;
    logic i_up_ok;
    logic j_dn_nz;
    logic i_dn_nz;
    logic term_empty;
    logic term_more;
  } flags_t;

  function automatic ctrl_word_t ucode(input upc_t pc);
    ctrl_word_t w;
    w = '{i_op: I_HOLD, j_op: J_HOLD, mem_wr: 1'b0, acc_op: ACC_HOLD,
          term_op: TERM_HOLD, out_stb: 1'b0, cond: C_ALWAYS, target: S_IDLE};
    case (pc)
      S_IDLE: begin
        w.cond   = C_NO_START;
        w.target = S_IDLE;
      end
      S_LOAD: begin
        w.i_op    = I_LOAD;
        w.j_op    = J_LOAD;
        w.acc_op  = ACC_CLEAR;
        w.term_op = TERM_CLEAR;
        w.cond    = C_QUERY;
        w.target  = S_Q_TERM;
      end
      S_A_RD: begin
        w.cond = C_NEVER;
      end
      S_A_WR: begin
        w.mem_wr = 1'b1;
        w.j_op   = J_UP;
        w.cond   = C_J_UP_OK;
        w.target = S_A_RD;
      end
      S_A_NXI: begin
        w.i_op   = I_UP;
        w.j_op   = J_RELOAD;
        w.cond   = C_I_UP_OK;
        w.target = S_A_RD;
      end
      S_A_DONE: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_Q_TERM: begin
        w.i_op   = I_LOAD;
        w.j_op   = J_LOAD;
        w.cond   = C_TERM_EMPTY;
        w.target = S_Q_END;
      end
      S_Q_RD: begin
        w.cond = C_NEVER;
      end
      S_Q_ACC: begin
        w.acc_op = ACC_ADD;
        w.j_op   = J_DOWN;
        w.cond   = C_J_DN_NZ;
        w.target = S_Q_RD;
      end
      S_Q_NXI: begin
        w.i_op   = I_DOWN;
        w.j_op   = J_RELOAD;
        w.cond   = C_I_DN_NZ;
        w.target = S_Q_RD;
      end
      S_Q_END: begin
        w.term_op = TERM_INC;
        w.cond    = C_TERM_MORE;
        w.target  = S_Q_TERM;
      end
      S_Q_OUT: begin
        w.out_stb = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: sv/grid_point_add_rect_sum.sv
// ----------------------------------------------------------------------------
// grid_point_add_rect_sum: two-dimensional rectangle sum engine
// A 256 by 256 binary indexed tree of 32-bit sums in a single-port memory,
// walked by a microcoded sequencer.
//
// An input word is taken at a clock edge where start is high and busy is low.
// A command of 0 adds in_amount at (in_col_a, in_row_a) and gives no result.
// A command of 1 returns the sum, modulo 2^32, of all earlier amounts in the
// inclusive rectangle spanned by the two corners; bounds in either order work.
// The result appears on out_rect_sum for exactly one cycle with out_valid
// high; the receiver must take it then, as it cannot stall the block.
// Each tree cell visited takes a step for the registered memory read and a
// step to write back or accumulate, plus a step per tree row. A query walks
// four prefix paths and registers its result from the last step. Busy drops
// as the result is shown, so the next word may be taken in that cycle.
// After reset the block clears the memory, one word a cycle, with busy held
// high throughout.
// ----------------------------------------------------------------------------
module grid_point_add_rect_sum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_col_a,
  input  logic [7:0]  in_row_a,
  input  logic [7:0]  in_col_b,
  input  logic [7:0]  in_row_b,
  input  logic [15:0] in_amount,
  output logic        out_valid,
  output logic [31:0] out_rect_sum
);

  localparam int COL_W  = gprs_pkg::COL_W;
  localparam int ROW_W  = gprs_pkg::ROW_W;
  localparam int CIDX_W = gprs_pkg::CIDX_W;
  localparam int RIDX_W = gprs_pkg::RIDX_W;
  localparam int ADDR_W = gprs_pkg::ADDR_W;
  localparam int SUM_W  = gprs_pkg::SUM_W;
  localparam int TERM_W = gprs_pkg::TERM_W;

  gprs_pkg::ctrl_word_t ctrl;
  gprs_pkg::flags_t     flags;
  logic                 seq_idle;
  logic                 accept;

  logic                 clearing_r;
  logic [ADDR_W-1:0]    clr_r;

  logic                 cmd_r;
  logic [COL_W-1:0]     col_lo_r, col_hi_r;
  logic [ROW_W-1:0]     row_lo_r, row_hi_r;
  logic [gprs_pkg::AMT_W-1:0] amount_r;

  logic [CIDX_W-1:0]    i_r, i_nxt;
  logic [RIDX_W-1:0]    j_r, j_nxt;
  logic [RIDX_W-1:0]    y_r, y_nxt;
  logic [TERM_W-1:0]    term_r;
  logic [SUM_W-1:0]     acc_r;
  logic                 out_valid_r;
  logic [SUM_W-1:0]     out_rect_sum_r;

  logic [SUM_W-1:0]     mem [0:(1 << ADDR_W) - 1];
  logic [SUM_W-1:0]     rd_q_r;
  logic [ADDR_W-1:0]    mem_addr;
  logic [ADDR_W-1:0]    cell_addr;
  logic                 mem_we;
  logic [SUM_W-1:0]     mem_wd;

  logic [CIDX_W-1:0]    tx, load_i;
  logic [RIDX_W-1:0]    ty, load_j;
  logic [CIDX_W:0]      i_up;
  logic [RIDX_W:0]      j_up;
  logic [CIDX_W-1:0]    i_dn, i_low;
  logic [RIDX_W-1:0]    j_dn, j_low;
  logic [CIDX_W-1:0]    i_m1;
  logic [RIDX_W-1:0]    j_m1;

  gprs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .idle  (seq_idle)
  );

  assign busy   = clearing_r || !seq_idle;
  assign accept = start && !busy;

  // Corner terms of the inclusion-exclusion, chosen by the term counter.
  assign tx = term_r[0] ? {1'b0, col_lo_r} : ({1'b0, col_hi_r} + CIDX_W'(1));
  assign ty = term_r[1] ? {1'b0, row_lo_r} : ({1'b0, row_hi_r} + RIDX_W'(1));

  assign load_i = cmd_r ? tx : ({1'b0, col_lo_r} + CIDX_W'(1));
  assign load_j = cmd_r ? ty : ({1'b0, row_lo_r} + RIDX_W'(1));

  assign i_low = i_r & (~i_r + CIDX_W'(1));
  assign j_low = j_r & (~j_r + RIDX_W'(1));
  assign i_up  = {1'b0, i_r} + {1'b0, i_low};
  assign j_up  = {1'b0, j_r} + {1'b0, j_low};
  assign i_dn  = i_r - i_low;
  assign j_dn  = j_r - j_low;

  always_comb begin
    flags.start      = start && !clearing_r;
    flags.query      = cmd_r;
    flags.j_up_ok    = (j_up <= (RIDX_W + 1)'(gprs_pkg::GRID_ROWS));
    flags.i_up_ok    = (i_up <= (CIDX_W + 1)'(gprs_pkg::GRID_COLS));
    flags.j_dn_nz    = (j_dn != '0);
    flags.i_dn_nz    = (i_dn != '0);
    flags.term_empty = (tx == '0) || (ty == '0);
    flags.term_more  = (term_r != {TERM_W{1'b1}});
  end

  always_comb begin
    case (ctrl.i_op)
      gprs_pkg::I_LOAD: i_nxt = load_i;
      gprs_pkg::I_UP:   i_nxt = i_up[CIDX_W-1:0];
      gprs_pkg::I_DOWN: i_nxt = i_dn;
      default:          i_nxt = i_r;
    endcase
    y_nxt = y_r;
    case (ctrl.j_op)
      gprs_pkg::J_LOAD: begin
        j_nxt = load_j;
        y_nxt = load_j;
      end
      gprs_pkg::J_UP:     j_nxt = j_up[RIDX_W-1:0];
      gprs_pkg::J_DOWN:   j_nxt = j_dn;
      gprs_pkg::J_RELOAD: j_nxt = y_r;
      default:            j_nxt = j_r;
    endcase
  end

  assign i_m1      = i_r - CIDX_W'(1);
  assign j_m1      = j_r - RIDX_W'(1);
  assign cell_addr = {i_m1[COL_W-1:0], j_m1[ROW_W-1:0]};
  assign mem_addr  = clearing_r ? clr_r : cell_addr;
  assign mem_we    = clearing_r || ctrl.mem_wr;
  assign mem_wd    = clearing_r ? '0 : (rd_q_r + SUM_W'(amount_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + ADDR_W'(1);
      if (clr_r == {ADDR_W{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      amount_r <= in_amount;
      if (in_cmd && (in_col_a > in_col_b)) begin
        col_lo_r <= in_col_b;
        col_hi_r <= in_col_a;
      end else begin
        col_lo_r <= in_col_a;
        col_hi_r <= in_col_b;
      end
      if (in_cmd && (in_row_a > in_row_b)) begin
        row_lo_r <= in_row_b;
        row_hi_r <= in_row_a;
      end else begin
        row_lo_r <= in_row_a;
        row_hi_r <= in_row_b;
      end
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    y_r <= y_nxt;
    case (ctrl.term_op)
      gprs_pkg::TERM_CLEAR: term_r <= '0;
      gprs_pkg::TERM_INC:   term_r <= term_r + TERM_W'(1);
      default:              term_r <= term_r;
    endcase
    case (ctrl.acc_op)
      gprs_pkg::ACC_CLEAR: acc_r <= '0;
      gprs_pkg::ACC_ADD: begin
        if (term_r[0] ^ term_r[1]) begin
          acc_r <= acc_r - rd_q_r;
        end else begin
          acc_r <= acc_r + rd_q_r;
        end
      end
      default: acc_r <= acc_r;
    endcase
    if (ctrl.out_stb) begin
      out_rect_sum_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.out_stb;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rect_sum = out_rect_sum_r;

endmodule

// File: sv/gprs_seq.sv
// ----------------------------------------------------------------------------
// gprs_seq: microprogram sequencer
// Holds the step counter, reads the control word from the microcode table
// and picks the next step from the selected jump condition.
// ----------------------------------------------------------------------------
module gprs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  gprs_pkg::flags_t    flags,
  output gprs_pkg::ctrl_word_t ctrl,
  output logic                idle
);

  gprs_pkg::upc_t upc_r;
  gprs_pkg::upc_t upc_nxt;
  logic           take;

  assign ctrl = gprs_pkg::ucode(upc_r);
  assign idle = (upc_r == gprs_pkg::S_IDLE);

  always_comb begin
    case (ctrl.cond)
      gprs_pkg::C_NEVER:      take = 1'b0;
      gprs_pkg::C_ALWAYS:     take = 1'b1;
      gprs_pkg::C_NO_START:   take = !flags.start;
      gprs_pkg::C_QUERY:      take = flags.query;
      gprs_pkg::C_J_UP_OK:    take = flags.j_up_ok;
      gprs_pkg::C_I_UP_OK:    take = flags.i_up_ok;
      gprs_pkg::C_J_DN_NZ:    take = flags.j_dn_nz;
      gprs_pkg::C_I_DN_NZ:    take = flags.i_dn_nz;
      gprs_pkg::C_TERM_EMPTY: take = flags.term_empty;
      gprs_pkg::C_TERM_MORE:  take = flags.term_more;
      default:                take = 1'b0;
    endcase
    upc_nxt = take ? ctrl.target : upc_r + gprs_pkg::upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= gprs_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: sv/gprs_chk.sv
// ----------------------------------------------------------------------------
// gprs_chk: port-level checks for the rectangle sum block
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module gprs_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_cmd,
  input logic out_valid
);

  // The memory clearing pass keeps the block busy straight after reset.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // A result is a single-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A result only follows a cycle in which the block was working.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result shown without preceding work");

  // An accepted word always occupies the block in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not start work");

  // An add word raises no result strobe from its load step.
  a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_cmd) |=> ##1 !out_valid)
    else $error("add word produced a result");

endmodule

bind grid_point_add_rect_sum gprs_chk u_gprs_chk (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the rectangle sum engine
// A queue of input words drives the block through a clocked driver; a Fenwick
// tree kept in the bench predicts each rectangle sum as words are accepted,
// and a clocked monitor compares every result strobe with the oldest sum due.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit CMD_ADD   = 1'b0;
  localparam bit CMD_QUERY = 1'b1;
  localparam int SETTLE_CYCLES = 600;

  typedef struct {
    bit        cmd;
    bit [7:0]  col_a;
    bit [7:0]  row_a;
    bit [7:0]  col_b;
    bit [7:0]  row_b;
    bit [15:0] amount;
    int        idle_pct;
    bit        drain;
  } grid_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = CMD_ADD;
  logic [7:0]  in_col_a = '0;
  logic [7:0]  in_row_a = '0;
  logic [7:0]  in_col_b = '0;
  logic [7:0]  in_row_b = '0;
  logic [15:0] in_amount = '0;
  logic        out_valid;
  logic [31:0] out_rect_sum;

  grid_word_t  word_q[$];
  bit [31:0]   due_sums[$];
  bit [31:0]   fen_cells [gprs_pkg::GRID_COLS*gprs_pkg::GRID_ROWS];
  int unsigned queries_sent = 0;
  int unsigned sums_seen = 0;
  int unsigned error_count = 0;
  bit [7:0]    hot_base = 8'd0;

  grid_point_add_rect_sum u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_col_a     (in_col_a),
    .in_row_a     (in_row_a),
    .in_col_b     (in_col_b),
    .in_row_b     (in_row_b),
    .in_amount    (in_amount),
    .out_valid    (out_valid),
    .out_rect_sum (out_rect_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [31:0] grid_prefix(int unsigned x, int unsigned y);
    bit [31:0]   total;
    int unsigned i;
    int unsigned j;
    total = '0;
    if (x > gprs_pkg::GRID_COLS) x = gprs_pkg::GRID_COLS;
    if (y > gprs_pkg::GRID_ROWS) y = gprs_pkg::GRID_ROWS;
    for (i = x; i != 0; i -= (i & (~i + 1))) begin
      for (j = y; j != 0; j -= (j & (~j + 1))) begin
        total += fen_cells[(i - 1) * gprs_pkg::GRID_ROWS + (j - 1)];
      end
    end
    return total;
  endfunction

  function automatic void grid_add(int unsigned col, int unsigned row, bit [15:0] amt);
    int unsigned i;
    int unsigned j;
    if (col >= gprs_pkg::GRID_COLS || row >= gprs_pkg::GRID_ROWS) return;
    for (i = col + 1; i <= gprs_pkg::GRID_COLS; i += (i & (~i + 1))) begin
      for (j = row + 1; j <= gprs_pkg::GRID_ROWS; j += (j & (~j + 1))) begin
        fen_cells[(i - 1) * gprs_pkg::GRID_ROWS + (j - 1)] += amt;
      end
    end
  endfunction

  function automatic bit [31:0] rect_total(bit [7:0] ca, bit [7:0] ra, bit [7:0] cb,
                                           bit [7:0] rb);
    int unsigned c_lo;
    int unsigned c_hi;
    int unsigned r_lo;
    int unsigned r_hi;
    c_lo = (ca < cb) ? ca : cb;
    c_hi = (ca < cb) ? cb : ca;
    r_lo = (ra < rb) ? ra : rb;
    r_hi = (ra < rb) ? rb : ra;
    return grid_prefix(c_hi + 1, r_hi + 1) - grid_prefix(c_lo, r_hi + 1)
         - grid_prefix(c_hi + 1, r_lo) + grid_prefix(c_lo, r_lo);
  endfunction

  function automatic grid_word_t make_word(bit cmd, bit [7:0] ca, bit [7:0] ra,
                                           bit [7:0] cb, bit [7:0] rb,
                                           bit [15:0] amt, int idle_pct);
    grid_word_t w;
    w.cmd      = cmd;
    w.col_a    = ca;
    w.row_a    = ra;
    w.col_b    = cb;
    w.row_b    = rb;
    w.amount   = amt;
    w.idle_pct = idle_pct;
    w.drain    = 1'b0;
    return w;
  endfunction

  // Coordinates are drawn mostly near a hot area or the grid edges so that
  // queries overlap earlier adds.
  function automatic bit [7:0] pick_coord();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1, 3: return hot_base + 8'($urandom_range(15));
      default: begin
        case ($urandom_range(3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
    endcase
  endfunction

  always @(posedge clk) begin : drive_words
    bit          took;
    bit          go;
    int unsigned sent_now;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      sent_now = queries_sent;
      if (took) begin
        if (in_cmd == CMD_QUERY) begin
          due_sums.push_back(rect_total(in_col_a, in_row_a, in_col_b, in_row_b));
          sent_now = queries_sent + 1;
          queries_sent <= sent_now;
        end else begin
          grid_add(in_col_a, in_row_a, in_amount);
        end
        void'(word_q.pop_front());
      end
      if (!(start && busy)) begin
        go = 1'b0;
        if (word_q.size() > 0) begin
          go = ($urandom_range(99) >= word_q[0].idle_pct) &&
               (!word_q[0].drain || sent_now == sums_seen);
        end
        if (go) begin
          start     <= 1'b1;
          in_cmd    <= word_q[0].cmd;
          in_col_a  <= word_q[0].col_a;
          in_row_a  <= word_q[0].row_a;
          in_col_b  <= word_q[0].col_b;
          in_row_b  <= word_q[0].row_b;
          in_amount <= word_q[0].amount;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_sums
    bit [31:0] want;
    if (rst_n && out_valid) begin
      if (due_sums.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %08h", $time,
                 out_rect_sum);
      end else begin
        want = due_sums.pop_front();
        if (out_rect_sum !== want) begin
          error_count++;
          $display("%0t: rect_sum mismatch, expected %08h, actual %08h", $time,
                   want, out_rect_sum);
        end
      end
      sums_seen <= sums_seen + 1;
    end
  end

  initial begin : run_words
    grid_word_t w;
    int         idle_pct;
    bit         cmd;

    // Empty grid, corners, amount extremes, swapped and mixed bound order,
    // rectangles touching the far edge of the grid.
    word_q.push_back(make_word(CMD_QUERY, 8'd0, 8'd0, 8'd255, 8'd255, 16'h0000, 0));
    word_q.push_back(make_word(CMD_ADD, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF, 0));
    word_q.push_back(make_word(CMD_ADD, 8'd255, 8'd255, 8'd0, 8'd0, 16'hFFFF, 0));
    word_q.push_back(make_word(CMD_ADD, 8'd255, 8'd0, 8'hAA, 8'h55, 16'h0001, 0));
    word_q.push_back(make_word(CMD_ADD, 8'd0, 8'd255, 8'h55, 8'hAA, 16'h8000, 0));
    word_q.push_back(make_word(CMD_ADD, 8'd128, 8'd127, 8'hFF, 8'hFF, 16'h0000, 0));
    word_q.push_back(make_word(CMD_ADD, 8'd128, 8'd127, 8'd3, 8'd9, 16'h5A5A, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd255, 8'd255, 8'd0, 8'd0, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd0, 8'd255, 8'd255, 8'd0, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd255, 8'd0, 8'd0, 8'd255, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd0, 8'd0, 8'd255, 8'd255, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd1, 8'd1, 8'd254, 8'd254, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd128, 8'd127, 8'd128, 8'd127, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd129, 8'd126, 8'd127, 8'd128, 16'h0, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd255, 8'd128, 8'd128, 8'd0, 16'h0, 0));
    word_q.push_back(make_word(CMD_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 0));
    word_q.push_back(make_word(CMD_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, 0));

    for (int n = 0; n < 1000; n++) begin
      if (n % 125 == 0) begin
        case ($urandom_range(2))
          0: hot_base = 8'd0;
          1: hot_base = 8'd240;
          default: hot_base = 8'($urandom_range(240));
        endcase
      end
      case ((n / 125) % 4)
        0: idle_pct = 0;
        1: idle_pct = 70;
        2: idle_pct = 0;
        default: idle_pct = 12;
      endcase
      cmd = ($urandom_range(1) == 0) ? CMD_ADD : CMD_QUERY;
      w = make_word(cmd, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    16'($urandom_range(16'hFFFF)), idle_pct);
      w.drain = (n % 200 == 0) || (n % 125 == 37);
      word_q.push_back(w);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (word_q.size() != 0 || start || queries_sent != sums_seen);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (error_count == 0 && due_sums.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (due_sums.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, due_sums.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
